// ===== hdl/ncc_pkg.sv =====
// Package for the nearest-centre classifier: payload structs, field widths,
// operation and register codes, and the pipeline tag type.
// No dependencies; ncc_dist, the top level and the checker import it.
`timescale 1ns / 1ps
`default_nettype none

package ncc_pkg;

  // Fixed widths of the item fields.
  localparam int SAMPLE_BITS = 16;
  localparam int IN_BANDS    = 8;
  localparam int SLOT_W      = 4;
  localparam int CLASS_W     = 4;
  localparam int DIST_W      = 37;
  localparam int SQ_W        = 2 * SAMPLE_BITS;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int BANDS_W     = 4;
  localparam int CNT_W       = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_BANDS_IN_USE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTRES_IN_USE = 1'd1;

  localparam logic [BANDS_W-1:0] BANDS_RESET   = 4'd8;
  localparam logic [CNT_W-1:0]   CENTRES_RESET = 5'd0;

  // Item operations.
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic                          operation;
    logic [SLOT_W-1:0]             centre_slot;
    logic signed [SAMPLE_BITS-1:0] band_0;
    logic signed [SAMPLE_BITS-1:0] band_1;
    logic signed [SAMPLE_BITS-1:0] band_2;
    logic signed [SAMPLE_BITS-1:0] band_3;
    logic signed [SAMPLE_BITS-1:0] band_4;
    logic signed [SAMPLE_BITS-1:0] band_5;
    logic signed [SAMPLE_BITS-1:0] band_6;
    logic signed [SAMPLE_BITS-1:0] band_7;
  } item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic               class_valid;
    logic [DIST_W-1:0]  best_distance;
  } result_t;

  // Travels with a centre row through the distance pipeline.
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] idx;
  } tag_t;

endpackage

`default_nettype wire

// ===== hdl/ncc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ncc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ncc_dist.sv =====
// Squared Euclidean distance unit: per-band squares in one stage, their sum
// in a second stage. Uses ncc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncc_dist import ncc_pkg::*; #(
  parameter int LANES = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [LANES*SAMPLE_BITS-1:0] pixel,
  input  wire logic [LANES*SAMPLE_BITS-1:0] centre,
  input  wire logic [LANES-1:0]             mask,
  input  wire tag_t                         tag_in,
  output logic      [DIST_W-1:0]            row_dist,
  output tag_t                              tag_out,
  output logic                              busy
);

  logic [SQ_W-1:0] sq_next [LANES];
  logic [SQ_W-1:0] sq      [LANES];
  tag_t            sq_tag;
  logic [DIST_W-1:0] sum;

  // Differences need one extra bit; their squares fit in twice the sample width.
  always_comb begin
    logic signed [SAMPLE_BITS:0]     diff;
    logic signed [2*SAMPLE_BITS+1:0] prod;
    for (int b = 0; b < LANES; b++) begin
      diff = {pixel[b*SAMPLE_BITS+SAMPLE_BITS-1], pixel[b*SAMPLE_BITS +: SAMPLE_BITS]}
           - {centre[b*SAMPLE_BITS+SAMPLE_BITS-1], centre[b*SAMPLE_BITS +: SAMPLE_BITS]};
      prod = diff * diff;
      sq_next[b] = mask[b] ? prod[SQ_W-1:0] : '0;
    end
  end

  always_comb begin
    sum = '0;
    for (int b = 0; b < LANES; b++) begin
      sum = sum + DIST_W'(sq[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_tag.vld  <= 1'b0;
      tag_out.vld <= 1'b0;
    end else begin
      sq_tag.vld  <= tag_in.vld;
      tag_out.vld <= sq_tag.vld;
    end
    for (int b = 0; b < LANES; b++) begin
      sq[b] <= sq_next[b];
    end
    sq_tag.idx  <= tag_in.idx;
    tag_out.idx <= sq_tag.idx;
    row_dist    <= sum;
  end

  assign busy = sq_tag.vld | tag_out.vld;

endmodule

`default_nettype wire

// ===== hdl/nearest_centre_classifier.sv =====
// Nearest-centre classifier top level: control sequencer, centre table and
// running minimum. Uses ncc_pkg, ncc_ram and ncc_dist.
//
// Usage. Items arrive on the item channel (item_valid / item_ready / item).
// A load item writes the band values of one centre into the table row chosen
// by centre_slot; a slot at or beyond MAX_CENTRES is dropped. A load leaves
// the block idle and produces no result, so loads can stream one per cycle.
// A classify item searches the first centres_in_use rows, at most MAX_CENTRES,
// and returns one transfer on the result channel (result_valid / result_ready /
// result) with the index of the nearest centre, ties going to the lowest index.
// Scan: the centre table has one read port and one row is read per cycle,
// after which the sequencer drains the distance pipeline and moves to the
// done state; the block takes no new item until it is back in idle. With
// no centres in use the sequencer goes straight from idle to done, and the
// result is flagged as having no class.
// Stalls: the result sits in an output register. While the receiver holds
// result_ready low the block still takes the next item; a second result
// waits in the final state until the register frees up.
// Reset (synchronous, active high) returns the sequencer to idle, drops any
// pending result and restores bands_in_use to 8 and centres_in_use to 0.
// The centre table is not cleared; rows must be loaded before use.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module nearest_centre_classifier import ncc_pkg::*; #(
  parameter int MAX_CENTRES = 16,
  parameter int BANDS       = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire item_t                  item,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output result_t                     result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Bands beyond the item's eight are never compared, so they are not stored.
  localparam int USED_BANDS = (BANDS < IN_BANDS) ? BANDS : IN_BANDS;
  localparam int ROW_W      = USED_BANDS * SAMPLE_BITS;
  localparam int AW         = (MAX_CENTRES > 1) ? $clog2(MAX_CENTRES) : 1;
  localparam int NC_CAP     = (MAX_CENTRES < 31) ? MAX_CENTRES : 31;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [BANDS_W-1:0] bands_in_use;
  logic [CNT_W-1:0]   centres_in_use;

  // Per-item context captured when a classify item is taken.
  logic [ROW_W-1:0]      pixel;
  logic [USED_BANDS-1:0] mask;
  logic [CNT_W-1:0]      nc;
  logic [CNT_W-1:0]      cnt;

  // Running minimum.
  logic              found;
  logic [CNT_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;

  logic signed [SAMPLE_BITS-1:0] in_band [IN_BANDS];
  logic [ROW_W-1:0]      row_wdata;
  logic                  accept;
  logic                  classify;
  logic                  slot_ok;
  logic                  ram_we;
  logic                  ram_re;
  logic [ROW_W-1:0]      ram_rdata;
  logic [BANDS_W-1:0]    nb_eff;
  logic [USED_BANDS-1:0] mask_next;
  logic [CNT_W-1:0]      nc_eff;
  logic                  out_free;
  logic                  better;
  tag_t                  rd_tag;
  tag_t                  dist_tag;
  logic [DIST_W-1:0]     row_dist;
  logic                  dist_busy;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid & item_ready;
  assign classify   = accept & (item.operation == OP_CLASSIFY);
  assign slot_ok    = int'(item.centre_slot) < MAX_CENTRES;
  assign ram_we     = accept & (item.operation == OP_LOAD) & slot_ok;
  assign ram_re     = (state == ST_SCAN);
  assign out_free   = ~result_valid | result_ready;
  assign better     = ~found | (row_dist < best_dist);

  always_comb begin
    in_band[0] = item.band_0;
    in_band[1] = item.band_1;
    in_band[2] = item.band_2;
    in_band[3] = item.band_3;
    in_band[4] = item.band_4;
    in_band[5] = item.band_5;
    in_band[6] = item.band_6;
    in_band[7] = item.band_7;
  end

  // One table row holds all bands of one centre, band 0 in the low bits.
  // The pixel register uses the same packing.
  always_comb begin
    for (int b = 0; b < USED_BANDS; b++) begin
      row_wdata[b*SAMPLE_BITS +: SAMPLE_BITS] = in_band[b];
    end
  end

  // A band count of zero acts as one; counts above the stored bands clamp.
  always_comb begin
    if (bands_in_use == '0) begin
      nb_eff = BANDS_W'(1);
    end else if (bands_in_use > BANDS_W'(USED_BANDS)) begin
      nb_eff = BANDS_W'(USED_BANDS);
    end else begin
      nb_eff = bands_in_use;
    end
    for (int b = 0; b < USED_BANDS; b++) begin
      mask_next[b] = BANDS_W'(b) < nb_eff;
    end
  end

  assign nc_eff = (centres_in_use > CNT_W'(NC_CAP)) ? CNT_W'(NC_CAP) : centres_in_use;

  ncc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CENTRES)
  ) u_centre_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(item.centre_slot)),
    .wdata (row_wdata),
    .re    (ram_re),
    .raddr (AW'(cnt)),
    .rdata (ram_rdata)
  );

  ncc_dist #(
    .LANES (USED_BANDS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel),
    .centre   (ram_rdata),
    .mask     (mask),
    .tag_in   (rd_tag),
    .row_dist (row_dist),
    .tag_out  (dist_tag),
    .busy     (dist_busy)
  );

  // Control: sequencer, configuration, read tag and result handshake.
  always_ff @(posedge clk) begin
    rd_tag.idx <= cnt;
    if (rst) begin
      state          <= ST_IDLE;
      bands_in_use   <= BANDS_RESET;
      centres_in_use <= CENTRES_RESET;
      rd_tag.vld     <= 1'b0;
      result_valid   <= 1'b0;
      cnt            <= '0;
      found          <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BANDS_IN_USE:   bands_in_use   <= cfg_data[BANDS_W-1:0];
          REG_CENTRES_IN_USE: centres_in_use <= cfg_data;
          default: ;
        endcase
      end

      rd_tag.vld <= ram_re;

      // A new result may replace the one being taken in the same cycle.
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      if (dist_tag.vld && better) begin
        found <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (classify) begin
            cnt   <= '0;
            found <= 1'b0;
            state <= (nc_eff == '0) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // One row read per cycle; the last read hands over to the drain.
          if (cnt == nc - CNT_W'(1)) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!rd_tag.vld && !dist_busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (classify) begin
      pixel     <= row_wdata;
      mask      <= mask_next;
      nc        <= nc_eff;
      best_idx  <= '0;
      best_dist <= '0;
    end else if (dist_tag.vld && better) begin
      // Strict compare keeps the lower index on ties, as rows arrive in order.
      best_idx  <= dist_tag.idx;
      best_dist <= row_dist;
    end

    if (state == ST_DONE && out_free) begin
      result.class_index   <= best_idx[CLASS_W-1:0];
      result.class_valid   <= found;
      result.best_distance <= best_dist;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ncc_checker.sv =====
// Port-level checker for the nearest-centre classifier, bound to the top level.
// Uses ncc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncc_checker import ncc_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_ready,
  input wire item_t   item,
  input wire logic    result_valid,
  input wire logic    result_ready,
  input wire result_t result
);

  // A result held by the receiver stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // A result without a class carries zero fields.
  a_no_class_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.class_valid |->
      result.class_index == '0 && result.best_distance == '0)
    else $error("no-class result has nonzero fields");

  // A classify transfer occupies the block for at least the next cycle.
  a_classify_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.operation == OP_CLASSIFY |=> !item_ready)
    else $error("item taken during classification");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind nearest_centre_classifier ncc_checker u_ncc_checker (.*);

`default_nettype wire
